// File: hdl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check on the rising clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Concurrent next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int QuatFracBits     = 14;
  localparam int CordicIterations = 16;
  localparam int QuatW            = 16;
  localparam int AccW             = 64;
  localparam int ZW               = 40;

  // Report kinds.
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindRot  = 2'd1;

  // Controller states.
  typedef enum logic [3:0] {
    StIdle,
    StProd,
    StSqrt,
    StPre,
    StIter,
    StPost,
    StOut
  } state_e;

  // Datapath operations for one work step.
  typedef enum logic [1:0] {
    OpRoll,
    OpPitch,
    OpYaw
  } angle_e;

  typedef struct packed {
    logic   load;
    logic   prod;
    logic   sqrt_init;
    logic   sqrt_step;
    logic   pre;
    logic   iter;
    logic   post;
    angle_e sel;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic iter_done;
  } stat_t;

  // atan(2^-i) in centidegrees times 65536.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 40'sd294912000;
      5'd1:  r = 40'sd174096719;
      5'd2:  r = 40'sd91987925;
      5'd3:  r = 40'sd46694507;
      5'd4:  r = 40'sd23437865;
      5'd5:  r = 40'sd11730358;
      5'd6:  r = 40'sd5866610;
      5'd7:  r = 40'sd2933484;
      5'd8:  r = 40'sd1466765;
      5'd9:  r = 40'sd733385;
      5'd10: r = 40'sd366693;
      5'd11: r = 40'sd183347;
      5'd12: r = 40'sd91673;
      5'd13: r = 40'sd45837;
      5'd14: r = 40'sd22918;
      5'd15: r = 40'sd11459;
      5'd16: r = 40'sd5730;
      5'd17: r = 40'sd2865;
      5'd18: r = 40'sd1432;
      5'd19: r = 40'sd716;
      5'd20: r = 40'sd358;
      5'd21: r = 40'sd179;
      5'd22: r = 40'sd90;
      5'd23: r = 40'sd45;
      5'd24: r = 40'sd22;
      5'd25: r = 40'sd11;
      5'd26: r = 40'sd6;
      5'd27: r = 40'sd3;
      5'd28: r = 40'sd1;
      5'd29: r = 40'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/q2e_ctrl.sv
// ----------------------------------------------------------------------------
// q2e_ctrl
// Sequencer: for rotation reports, products, square root, then three CORDIC passes;
// other kinds go straight to the output.
`include "assert_macros.svh"
module q2e_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_hs_i,
  input  logic          in_rot_i,
  input  logic          out_free_i,
  input  q2e_pkg::stat_t stat_i,
  output logic          busy_o,
  output logic          out_load_o,
  output q2e_pkg::cmd_t cmd_o
);

  q2e_pkg::state_e state_q, state_d;
  q2e_pkg::angle_e sel_q, sel_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= q2e_pkg::StIdle;
      sel_q   <= q2e_pkg::OpRoll;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    out_load_o = 1'b0;
    busy_o     = (state_q != q2e_pkg::StIdle);
    case (state_q)
      q2e_pkg::StIdle: begin
        if (in_hs_i) begin
          cmd_o.load = 1'b1;
          sel_d      = q2e_pkg::OpRoll;
          state_d    = in_rot_i ? q2e_pkg::StProd : q2e_pkg::StOut;
        end
      end
      q2e_pkg::StProd: begin
        cmd_o.prod = 1'b1;
        state_d    = q2e_pkg::StSqrt;
      end
      q2e_pkg::StSqrt: begin
        if (sel_q == q2e_pkg::OpRoll) begin
          cmd_o.sqrt_init = 1'b1;
          sel_d = q2e_pkg::OpPitch;
        end else if (!stat_i.sqrt_done) begin
          cmd_o.sqrt_step = 1'b1;
        end else begin
          sel_d   = q2e_pkg::OpRoll;
          state_d = q2e_pkg::StPre;
        end
      end
      q2e_pkg::StPre: begin
        cmd_o.pre = 1'b1;
        state_d   = q2e_pkg::StIter;
      end
      q2e_pkg::StIter: begin
        cmd_o.iter = 1'b1;
        if (stat_i.iter_done) state_d = q2e_pkg::StPost;
      end
      q2e_pkg::StPost: begin
        cmd_o.post = 1'b1;
        case (sel_q)
          q2e_pkg::OpRoll:  begin sel_d = q2e_pkg::OpPitch; state_d = q2e_pkg::StPre; end
          q2e_pkg::OpPitch: begin sel_d = q2e_pkg::OpYaw;   state_d = q2e_pkg::StPre; end
          default:          state_d = q2e_pkg::StOut;
        endcase
      end
      q2e_pkg::StOut: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = q2e_pkg::StIdle;
        end
      end
      default: state_d = q2e_pkg::StIdle;
    endcase
  end

  `ASSERT_IMPL(a_load_idle, clk_i, rst_ni, cmd_o.load, state_q == q2e_pkg::StIdle, "load outside idle")
  `ASSERT_NEXT(a_iter_stays, clk_i, rst_ni, cmd_o.iter && !stat_i.iter_done, state_q == q2e_pkg::StIter, "left iteration early")
  `ASSERT_IMPL(a_out_free, clk_i, rst_ni, out_load_o, out_free_i, "result overwritten")

endmodule

// File: hdl/q2e_datapath.sv
// ----------------------------------------------------------------------------
// q2e_datapath
// Products, bit-serial square root and a shared vectoring CORDIC.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module q2e_datapath #(
  parameter int QuatFracBits     = q2e_pkg::QuatFracBits,
  parameter int CordicIterations = q2e_pkg::CordicIterations
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  q2e_pkg::cmd_t               cmd_i,
  input  logic [1:0]                  kind_i,
  input  logic signed [QuatFracBits+1:0] qr_i,
  input  logic signed [QuatFracBits+1:0] qi_i,
  input  logic signed [QuatFracBits+1:0] qj_i,
  input  logic signed [QuatFracBits+1:0] qk_i,
  output q2e_pkg::stat_t              stat_o,
  output logic signed [15:0]          roll_o,
  output logic signed [14:0]          pitch_o,
  output logic [15:0]                 heading_o,
  output logic                        fresh_o
);

  localparam int QW  = QuatFracBits + 2;
  localparam int AW  = q2e_pkg::AccW;
  localparam int ZW  = q2e_pkg::ZW;
  localparam int Sh  = 2 * QuatFracBits - 30;
  localparam int ItW = $clog2(CordicIterations + 1);
  localparam logic signed [AW-1:0] Q30One = 64'sd1 << 30;

  logic signed [QW-1:0] r_q, i_q, j_q, k_q;
  logic signed [AW-1:0] ry_q, rx_q, ps_q, yy_q, yx_q, pc_q;
  logic signed [AW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [ItW-1:0]       it_q;
  logic                 zero_q;
  logic [AW-1:0]        rem_q, res_q, bit_q;
  logic signed [15:0]   roll_q;
  logic signed [14:0]   pitch_q;
  logic [15:0]          held_q;
  logic                 fresh_q;

  // Bring a Q(2F) sum to Q30.
  function automatic logic signed [AW-1:0] to_q30(input logic signed [AW-1:0] v);
    if (Sh >= 0) return v >>> Sh;
    else         return v <<< (-Sh);
  endfunction

  function automatic logic signed [AW-1:0] clampv(input logic signed [AW-1:0] v,
                                                  input logic signed [AW-1:0] lim);
    if (v < -lim)     return -lim;
    else if (v > lim) return lim;
    else              return v;
  endfunction

  // Products in one step; operands are narrow.
  logic signed [AW-1:0] p_ri, p_jk, p_ii, p_jj, p_rj, p_ki, p_rk, p_ij, p_kk, one;
  always_comb begin
    one  = 64'sd1 <<< (2 * QuatFracBits);
    p_ri = AW'(r_q) * AW'(i_q);
    p_jk = AW'(j_q) * AW'(k_q);
    p_ii = AW'(i_q) * AW'(i_q);
    p_jj = AW'(j_q) * AW'(j_q);
    p_rj = AW'(r_q) * AW'(j_q);
    p_ki = AW'(k_q) * AW'(i_q);
    p_rk = AW'(r_q) * AW'(k_q);
    p_ij = AW'(i_q) * AW'(j_q);
    p_kk = AW'(k_q) * AW'(k_q);
  end

  // Square of the clamped pitch sine; it fits in 32 signed bits.
  logic signed [31:0]   ps_n;
  logic signed [AW-1:0] ps_sq;
  always_comb begin
    ps_n  = 32'(ps_q);
    ps_sq = ps_n * ps_n;
  end

  // CORDIC inputs for the selected angle.
  logic signed [AW-1:0] sy, sx;
  always_comb begin
    case (cmd_i.sel)
      q2e_pkg::OpRoll:  begin sy = ry_q; sx = rx_q; end
      q2e_pkg::OpPitch: begin sy = ps_q; sx = pc_q; end
      default:          begin sy = yy_q; sx = yx_q; end
    endcase
  end

  logic [4:0] sidx;
  logic signed [AW-1:0] xs, ys;
  logic signed [ZW-1:0] zr;
  logic signed [AW-1:0] ang, ywr;
  logic [AW-1:0] trial;
  always_comb begin
    sidx  = 5'(it_q);
    xs    = x_q >>> sidx;
    ys    = y_q >>> sidx;
    zr    = (z_q + ZW'(32768)) >>> 16;
    ang   = zero_q ? '0 : AW'(zr);
    ywr   = clampv(ang, 64'sd18000);
    if (ywr < 0) ywr = ywr + 64'sd36000;
    if (ywr >= 64'sd36000) ywr = ywr - 64'sd36000;
    trial = res_q + bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      fresh_q <= 1'b0;
      it_q    <= '0;
      roll_q  <= '0;
      pitch_q <= '0;
    end else begin
      if (cmd_i.load) begin
        r_q <= qr_i; i_q <= qi_i; j_q <= qj_i; k_q <= qk_i;
        fresh_q <= (kind_i == q2e_pkg::KindRot);
        roll_q  <= '0;
        pitch_q <= '0;
      end
      if (cmd_i.prod) begin
        ry_q <= to_q30(2 * (p_ri + p_jk));
        rx_q <= to_q30(one - 2 * (p_ii + p_jj));
        ps_q <= clampv(to_q30(2 * (p_rj - p_ki)), Q30One);
        yy_q <= to_q30(2 * (p_rk + p_ij));
        yx_q <= to_q30(one - 2 * (p_jj + p_kk));
      end
      // Square root, one result bit per step.
      if (cmd_i.sqrt_init) begin
        rem_q <= AW'(64'sd1 <<< 60) - AW'(ps_sq);
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      if (cmd_i.sqrt_step) begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == 64'd1 || bit_q == 64'd0) pc_q <= (rem_q >= trial) ?
            AW'((res_q >> 1) + bit_q) : AW'(res_q >> 1);
      end
      // CORDIC pre-rotation.
      if (cmd_i.pre) begin
        it_q   <= '0;
        zero_q <= (sx == 0) && (sy == 0);
        if (sx < 0) begin
          if (sy >= 0) begin x_q <= sy; y_q <= -sx; z_q <= 40'sd589824000; end
          else         begin x_q <= -sy; y_q <= sx; z_q <= -40'sd589824000; end
        end else begin
          x_q <= sx; y_q <= sy; z_q <= '0;
        end
      end
      if (cmd_i.iter && !stat_o.iter_done) begin
        it_q <= it_q + 1'b1;
        if (y_q >= 0) begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + q2e_pkg::atan_lut(sidx);
        end else begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - q2e_pkg::atan_lut(sidx);
        end
      end
      if (cmd_i.post) begin
        case (cmd_i.sel)
          q2e_pkg::OpRoll:  roll_q  <= 16'(clampv(ang, 64'sd18000));
          q2e_pkg::OpPitch: pitch_q <= 15'(clampv(ang, 64'sd9000));
          default:          held_q  <= 16'(ywr);
        endcase
      end
    end
  end

  assign stat_o.sqrt_done = (bit_q == '0);
  assign stat_o.iter_done = (it_q == ItW'(CordicIterations));
  assign roll_o    = roll_q;
  assign pitch_o   = pitch_q;
  assign heading_o = held_q;
  assign fresh_o   = fresh_q;

  `ASSERT_IMPL(a_held_range, clk_i, rst_ni, 1'b1, held_q < 16'd36000, "heading out of range")
  `ASSERT_IMPL(a_pitch_range, clk_i, rst_ni, 1'b1, pitch_q <= 15'sd9000 && pitch_q >= -15'sd9000, "pitch out of range")

endmodule

// File: hdl/quaternion_to_euler_yaw_hold.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_yaw_hold
// Quaternion to ZYX Euler angles with a held heading.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields
// s_axis   in         tuser: report_kind; tdata: quat_real, quat_i, quat_j, quat_k
// m_axis   out        tuser: fresh; tdata: roll_angle, pitch_angle, heading
//
// A rotation vector is worked by the shared CORDIC, once per angle, after the
// 32-step square root; other kinds go straight to the output register.
// One item is worked at a time; s_axis_tready is low while busy.
// The output register is loaded only once it is free, so a stall holds the result.
// Reset clears the held heading to zero.
module quaternion_to_euler_yaw_hold #(
  parameter int QuatFracBits     = q2e_pkg::QuatFracBits,
  parameter int CordicIterations = q2e_pkg::CordicIterations
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_real, quat_i, quat_j, quat_k (16 each)
  input  logic [1:0]  s_axis_tuser,   // report_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle 16, pitch_angle 15, heading 16, pad
  output logic        m_axis_tuser    // fresh
);

  localparam int QW = QuatFracBits + 2;

  q2e_pkg::cmd_t  cmd;
  q2e_pkg::stat_t stat;
  logic busy, out_load, in_hs;
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic [15:0] heading;
  logic fresh;
  logic [47:0] data_q;
  logic user_q, valid_q;

  assign s_axis_tready = !busy;
  assign in_hs = s_axis_tvalid && s_axis_tready;

  q2e_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_hs_i(in_hs),
    .in_rot_i(s_axis_tuser == q2e_pkg::KindRot),
    .out_free_i(!valid_q || m_axis_tready),
    .stat_i(stat), .busy_o(busy), .out_load_o(out_load), .cmd_o(cmd)
  );

  q2e_datapath #(.QuatFracBits(QuatFracBits), .CordicIterations(CordicIterations)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .kind_i(s_axis_tuser),
    .qr_i(QW'($signed(s_axis_tdata[15:0]))),
    .qi_i(QW'($signed(s_axis_tdata[31:16]))),
    .qj_i(QW'($signed(s_axis_tdata[47:32]))),
    .qk_i(QW'($signed(s_axis_tdata[63:48]))),
    .stat_o(stat), .roll_o(roll), .pitch_o(pitch), .heading_o(heading), .fresh_o(fresh)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_load) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      data_q <= {1'b0, heading, pitch, roll};
      user_q <= fresh;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule
